[hdl/mfps_pkg.sv]
// ----------------------------------------------------------------------------
// mfps_pkg
// Types, codes and decode helpers shared by the MIPS-subset pipeline step block.
// ----------------------------------------------------------------------------
package mfps_pkg;

  typedef enum logic [2:0] {
    REQ_STEP     = 3'd0,
    REQ_DM_WRITE = 3'd1,
    REQ_DM_READ  = 3'd2,
    REQ_RF_WRITE = 3'd3,
    REQ_RF_READ  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ALU_AND  = 3'd0,
    ALU_OR   = 3'd1,
    ALU_ADD  = 3'd2,
    ALU_SLT  = 3'd3,
    ALU_XOR  = 3'd4,
    ALU_ZERO = 3'd5
  } alu_op_t;

  typedef enum logic [1:0] {
    SRC_RT   = 2'd0,
    SRC_SEXT = 2'd1,
    SRC_ZEXT = 2'd2,
    SRC_LUI  = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    BC_SEQ   = 2'd0,
    BC_TAKEN = 2'd1,
    BC_JUMP  = 2'd2
  } bc_t;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  localparam logic [5:0] FN_NOP  = 6'd0;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLT  = 6'd42;

  typedef struct packed {
    src_t    src;
    alu_op_t alu_op;
    logic    neg;
    logic    mem_rd;
    logic    mem_wr;
    logic    m2r;
    logic    reg_dst;
    logic    reg_wr;
  } idex_ctl_t;

  typedef struct packed {
    idex_ctl_t   ctl;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] a_val;
    logic [31:0] b_val;
    logic [15:0] imm;
  } idex_t;

  typedef struct packed {
    logic        reg_wr;
    logic        mem_rd;
    logic        mem_wr;
    logic        m2r;
    logic [4:0]  wreg;
    logic [4:0]  rt;
    logic [31:0] alu_res;
    logic [31:0] rt_val;
  } exmem_t;

  typedef struct packed {
    logic        reg_wr;
    logic        m2r;
    logic [4:0]  wreg;
    logic [31:0] alu_res;
  } memwb_t;

  typedef struct packed {
    logic      valid;
    idex_ctl_t ctl;
  } dec_t;

  function automatic idex_ctl_t mk_ctl(src_t src, alu_op_t op, logic neg, logic mr,
                                       logic mw, logic m2r, logic rdst, logic rw);
    idex_ctl_t c;
    c.src     = src;
    c.alu_op  = op;
    c.neg     = neg;
    c.mem_rd  = mr;
    c.mem_wr  = mw;
    c.m2r     = m2r;
    c.reg_dst = rdst;
    c.reg_wr  = rw;
    return c;
  endfunction

  // Decode opcode and funct into ID/EX control; branches and jumps give no control
  function automatic dec_t decode(logic [5:0] op, logic [5:0] funct);
    dec_t d;
    d.valid = 1'b1;
    d.ctl   = '0;
    case (op)
      OP_RTYPE: begin
        case (funct)
          FN_NOP:           d.ctl = mk_ctl(SRC_RT, ALU_ZERO, 0, 0, 0, 0, 1, 1);
          FN_ADD, FN_ADDU:  d.ctl = mk_ctl(SRC_RT, ALU_ADD, 0, 0, 0, 0, 1, 1);
          FN_SUB, FN_SUBU:  d.ctl = mk_ctl(SRC_RT, ALU_ADD, 1, 0, 0, 0, 1, 1);
          FN_AND:           d.ctl = mk_ctl(SRC_RT, ALU_AND, 0, 0, 0, 0, 1, 1);
          FN_OR:            d.ctl = mk_ctl(SRC_RT, ALU_OR, 0, 0, 0, 0, 1, 1);
          FN_XOR:           d.ctl = mk_ctl(SRC_RT, ALU_XOR, 0, 0, 0, 0, 1, 1);
          FN_NOR:           d.ctl = mk_ctl(SRC_RT, ALU_OR, 1, 0, 0, 0, 1, 1);
          FN_SLT:           d.ctl = mk_ctl(SRC_RT, ALU_SLT, 1, 0, 0, 0, 1, 1);
          default:          d.valid = 1'b0;
        endcase
      end
      OP_BEQ, OP_BNE, OP_J: d.ctl = '0;
      OP_ADDI, OP_ADDIU:    d.ctl = mk_ctl(SRC_SEXT, ALU_ADD, 0, 0, 0, 0, 0, 1);
      OP_SLTI:              d.ctl = mk_ctl(SRC_SEXT, ALU_SLT, 1, 0, 0, 0, 0, 1);
      OP_ANDI:              d.ctl = mk_ctl(SRC_ZEXT, ALU_AND, 0, 0, 0, 0, 0, 1);
      OP_ORI:               d.ctl = mk_ctl(SRC_ZEXT, ALU_OR, 0, 0, 0, 0, 0, 1);
      OP_LUI:               d.ctl = mk_ctl(SRC_LUI, ALU_ADD, 0, 0, 0, 0, 0, 1);
      OP_LW:                d.ctl = mk_ctl(SRC_SEXT, ALU_ADD, 0, 1, 0, 1, 0, 1);
      OP_SW:                d.ctl = mk_ctl(SRC_SEXT, ALU_ADD, 0, 0, 1, 0, 0, 0);
      default:              d.valid = 1'b0;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] alu(alu_op_t op, logic neg, logic [31:0] a,
                                      logic [31:0] b);
    logic [31:0] r;
    case (op)
      ALU_AND: r = a & b;
      ALU_OR:  r = neg ? ~(a | b) : (a | b);
      ALU_ADD: r = neg ? a - b : a + b;
      ALU_SLT: r = {31'd0, ($signed(a) < $signed(b))};
      ALU_XOR: r = a ^ b;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/mips_five_stage_pipeline_step.sv]
// ----------------------------------------------------------------------------
// mips_five_stage_pipeline_step
// ID/EX/MEM/WB step of a MIPS-subset pipeline with forwarding; register file
// and data memory live in synchronous RAMs, plus direct access requests.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// req      req_valid/req_ready   req_type, instruction, pc_plus_4, access_index,
//                                write_data
// res      res_valid/res_ready   stall_res, branch_control, target_address,
//                                invalid_instruction, read_data
//
// One request per cycle unless results back up; results are registered from s1.
// The accept cycle issues register file reads and any direct data memory read;
// the firing cycle decodes, executes, writes back and loads the result register.
// Loads are read in the step that performs MEM and used in the following one.
// Reset clears control and register file valid bits; no clearing pass is run.
// DATA_WORDS must be a power of two.
// ----------------------------------------------------------------------------
module mips_five_stage_pipeline_step
  import mfps_pkg::*;
#(
  parameter int DATA_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] instruction,
  input  logic [31:0] pc_plus_4,
  input  logic [9:0]  access_index,
  input  logic [31:0] write_data,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        stall_res,
  output logic [1:0]  branch_control,
  output logic [31:0] target_address,
  output logic        invalid_instruction,
  output logic [31:0] read_data
);

  localparam int AW = $clog2(DATA_WORDS);

  // Handshake and the execute stage
  logic        s1_valid;
  logic [2:0]  s1_req;
  logic [31:0] s1_ins;
  logic [31:0] s1_pc4;
  logic [9:0]  s1_idx;
  logic [31:0] s1_wdata;
  logic        out_free, s1_fire, accept, s1_step;

  assign out_free  = !res_valid || res_ready;
  assign s1_fire   = s1_valid && out_free;
  assign req_ready = !s1_valid || out_free;
  assign accept    = req_valid && req_ready;
  assign s1_step   = (s1_req == REQ_STEP);

  // Pipeline registers
  idex_t       ix;
  exmem_t      em;
  memwb_t      mw;
  logic [31:0] mw_mem_val;
  logic        ld_pend;

  // Register file RAM ports and read-side bypass
  logic [31:0] rf_vld;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic [4:0]  ra_rs, ra_rt;
  logic [31:0] rf_rs_dout, rf_rt_dout;
  logic        rs_vld_q, rt_vld_q, rs_byp_q, rt_byp_q;
  logic [31:0] rs_byp_data, rt_byp_data;

  // Data memory RAM ports
  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0]   dm_wdata;
  logic [AW-1:0] dm_req_addr, dm_ld_addr;
  logic [AW+9:0] idx_ext;
  logic          dm_ld_re;
  logic [31:0]   dm_a_dout, dm_b_dout;
  logic          dm_byp_q;
  logic [31:0]   dm_byp_data;

  assign ra_rs       = (req_type == REQ_RF_READ) ? access_index[4:0] : instruction[25:21];
  assign ra_rt       = instruction[20:16];
  assign idx_ext     = {{AW{1'b0}}, access_index};
  assign dm_req_addr = idx_ext[AW-1:0];
  assign dm_ld_addr  = em.alu_res[AW+1:2];

  mfps_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rs (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .re(accept), .raddr(ra_rs), .rdata(rf_rs_dout)
  );

  mfps_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rt (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .re(accept), .raddr(ra_rt), .rdata(rf_rt_dout)
  );

  mfps_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dm_req (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(accept && (req_type == REQ_DM_READ)), .raddr(dm_req_addr), .rdata(dm_a_dout)
  );

  mfps_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dm_ld (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .re(dm_ld_re), .raddr(dm_ld_addr), .rdata(dm_b_dout)
  );

  function automatic logic [31:0] pc_plus_step(logic [31:0] pc4, logic [15:0] off);
    return pc4 + {{14{off[15]}}, off, 2'b00};
  endfunction

  function automatic logic [AW-1:0] s1_idx_addr(logic [9:0] idx);
    logic [AW+9:0] e;
    e = {{AW{1'b0}}, idx};
    return e[AW-1:0];
  endfunction

  // Execute-stage combinational logic
  logic [4:0]  wb_w;
  logic        wb_we;
  logic [31:0] mwv1, wb_val, st_val;
  logic [31:0] fa, fb, opb, ex_res;
  exmem_t      n_em;
  memwb_t      n_mw;
  idex_t       n_ix;
  logic [5:0]  op, funct;
  logic [4:0]  rs, rt, rd;
  logic [15:0] imm;
  logic [31:0] rs_raw, rt_raw, rsv, rtv;
  logic        load, stall, carry;
  logic [4:0]  iw;
  dec_t        dec;
  logic [1:0]  bc;
  logic [31:0] target, br_target;
  logic        invalid;

  always_comb begin
    // Write back from old MEM/WB
    wb_w   = mw.wreg;
    wb_we  = mw.reg_wr && (wb_w != 5'd0);
    mwv1   = ld_pend ? dm_b_dout : mw_mem_val;
    wb_val = mw.m2r ? mwv1 : mw.alu_res;

    // MEM with store data forwarding from MEM/WB
    st_val = em.rt_val;
    if (mw.reg_wr && (wb_w == em.rt) && (em.rt != 5'd0)) begin
      st_val = wb_val;
    end
    n_mw.reg_wr  = em.reg_wr;
    n_mw.m2r     = em.m2r;
    n_mw.wreg    = em.wreg;
    n_mw.alu_res = em.alu_res;

    // EX with forwarding
    fa = ix.a_val;
    if (em.reg_wr && (em.wreg == ix.rs) && (em.wreg != 5'd0)) begin
      fa = em.alu_res;
    end else if (wb_we && (wb_w == ix.rs)) begin
      fa = wb_val;
    end
    fb = ix.b_val;
    if (em.reg_wr && (em.wreg == ix.rt) && (em.wreg != 5'd0)) begin
      fb = em.alu_res;
    end else if (wb_we && (wb_w == ix.rt)) begin
      fb = wb_val;
    end
    case (ix.ctl.src)
      SRC_SEXT: opb = {{16{ix.imm[15]}}, ix.imm};
      SRC_ZEXT: opb = {16'd0, ix.imm};
      SRC_LUI:  opb = {ix.imm, 16'd0};
      default:  opb = fb;
    endcase
    ex_res       = alu(ix.ctl.alu_op, ix.ctl.neg, fa, opb);
    n_em.reg_wr  = ix.ctl.reg_wr;
    n_em.mem_rd  = ix.ctl.mem_rd;
    n_em.mem_wr  = ix.ctl.mem_wr;
    n_em.m2r     = ix.ctl.m2r;
    n_em.wreg    = ix.ctl.reg_dst ? ix.rd : ix.rt;
    n_em.rt      = ix.rt;
    n_em.alu_res = ex_res;
    n_em.rt_val  = ix.b_val;

    // ID: register values as they stand after this write-back
    op     = s1_ins[31:26];
    rs     = s1_ins[25:21];
    rt     = s1_ins[20:16];
    rd     = s1_ins[15:11];
    funct  = s1_ins[5:0];
    imm    = s1_ins[15:0];
    rs_raw = rs_byp_q ? rs_byp_data : (rs_vld_q ? rf_rs_dout : 32'd0);
    rt_raw = rt_byp_q ? rt_byp_data : (rt_vld_q ? rf_rt_dout : 32'd0);
    rsv    = (wb_we && (wb_w == rs)) ? wb_val : rs_raw;
    rtv    = (wb_we && (wb_w == rt)) ? wb_val : rt_raw;

    // Hazard detection
    load  = ix.ctl.mem_rd && ix.ctl.reg_wr;
    iw    = ix.ctl.reg_dst ? ix.rd : ix.rt;
    stall = 1'b0;
    case (op)
      OP_RTYPE: stall = load && ((ix.rt == rs) || (ix.rt == rt));
      OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_LUI, OP_LW:
        stall = load && (ix.rt == rs);
      OP_SW: begin
        if (load && (ix.rt == rs)) begin
          stall = 1'b1;
        end else if (ix.ctl.reg_wr && (iw == rt)) begin
          stall = 1'b0;
        end else begin
          stall = em.reg_wr && (em.wreg == rt) && (rt != 5'd0);
        end
      end
      default: stall = 1'b0;
    endcase

    // Decode and branch resolution
    dec       = decode(op, funct);
    carry     = !((op == OP_BEQ) || (op == OP_BNE) || (op == OP_J));
    br_target = pc_plus_step(s1_pc4, imm);
    bc        = BC_SEQ;
    target    = 32'd0;
    if (!stall) begin
      case (op)
        OP_BEQ: begin
          if (rsv == rtv) begin
            bc     = BC_TAKEN;
            target = br_target;
          end
        end
        OP_BNE: begin
          if (rsv != rtv) begin
            bc     = BC_TAKEN;
            target = br_target;
          end
        end
        OP_J: begin
          bc     = BC_JUMP;
          target = {s1_pc4[31:28], s1_ins[25:0], 2'b00};
        end
        default: bc = BC_SEQ;
      endcase
    end
    invalid = !stall && !dec.valid;

    n_ix = '0;
    if (!stall && dec.valid && carry) begin
      n_ix.ctl   = dec.ctl;
      n_ix.rs    = rs;
      n_ix.rt    = rt;
      n_ix.rd    = rd;
      n_ix.a_val = rsv;
      n_ix.b_val = rtv;
      n_ix.imm   = imm;
    end
  end

  // RAM write ports
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = wb_w;
    rf_wdata = wb_val;
    if (s1_fire && s1_step) begin
      rf_we = wb_we;
    end else if (s1_fire && (s1_req == REQ_RF_WRITE)) begin
      rf_we    = (s1_idx[9:5] == 5'd0) && (s1_idx[4:0] != 5'd0);
      rf_waddr = s1_idx[4:0];
      rf_wdata = s1_wdata;
    end

    dm_we    = 1'b0;
    dm_waddr = dm_ld_addr;
    dm_wdata = st_val;
    if (s1_fire && s1_step) begin
      dm_we = !em.mem_rd && em.mem_wr;
    end else if (s1_fire && (s1_req == REQ_DM_WRITE)) begin
      dm_we    = 1'b1;
      dm_waddr = s1_idx_addr(s1_idx);
      dm_wdata = s1_wdata;
    end
    dm_ld_re = s1_fire && s1_step && em.mem_rd;
  end

  // Capture request, read bypasses and valid bits on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_req      <= req_type;
      s1_ins      <= instruction;
      s1_pc4      <= pc_plus_4;
      s1_idx      <= access_index;
      s1_wdata    <= write_data;
      rs_vld_q    <= rf_vld[ra_rs];
      rt_vld_q    <= rf_vld[ra_rt];
      rs_byp_q    <= rf_we && (rf_waddr == ra_rs);
      rt_byp_q    <= rf_we && (rf_waddr == ra_rt);
      rs_byp_data <= rf_wdata;
      rt_byp_data <= rf_wdata;
      dm_byp_q    <= dm_we && (dm_waddr == dm_req_addr);
      dm_byp_data <= dm_wdata;
    end
  end

  // Register file valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (rf_we) begin
      rf_vld[rf_waddr] <= 1'b1;
    end
  end

  // Advance pipeline registers; hold the loaded word once it returns
  always_ff @(posedge clk) begin
    if (rst) begin
      ix         <= '0;
      em         <= '0;
      mw         <= '0;
      ld_pend    <= 1'b0;
      mw_mem_val <= 32'd0;
    end else if (s1_fire && s1_step) begin
      ix         <= n_ix;
      em         <= n_em;
      mw         <= n_mw;
      ld_pend    <= em.mem_rd;
      mw_mem_val <= 32'd0;
    end else if (ld_pend) begin
      ld_pend    <= 1'b0;
      mw_mem_val <= dm_b_dout;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (s1_fire) begin
      stall_res           <= 1'b0;
      branch_control      <= BC_SEQ;
      target_address      <= 32'd0;
      invalid_instruction <= 1'b0;
      read_data           <= 32'd0;
      case (s1_req)
        REQ_STEP: begin
          stall_res           <= stall;
          branch_control      <= bc;
          target_address      <= target;
          invalid_instruction <= invalid;
        end
        REQ_DM_READ: read_data <= dm_byp_q ? dm_byp_data : dm_a_dout;
        REQ_RF_READ: read_data <= (s1_idx[9:5] == 5'd0) ? rs_raw : 32'd0;
        default:     read_data <= 32'd0;
      endcase
    end
  end

`ifndef SYNTH
  a_stall_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && stall_res |-> (branch_control == BC_SEQ) && !invalid_instruction)
    else $error("stalled step reports a branch or invalid word");

  a_bc_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (branch_control != 2'd3))
    else $error("branch control out of range");

  a_ld_pend: assert property (@(posedge clk) disable iff (rst)
    ld_pend |-> mw.m2r && mw.reg_wr)
    else $error("load pending without a load in MEM/WB");

  a_r0_clear: assert property (@(posedge clk) disable iff (rst)
    !rf_vld[0])
    else $error("register zero marked written");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> s1_valid && res_valid && !res_ready)
    else $error("request side blocked without back pressure");
`endif

endmodule

[hdl/mfps_ram.sv]
// ----------------------------------------------------------------------------
// mfps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mfps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read of the address being written returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[test/mfps_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfps_checker
// Watches both channels of the pipeline step block, keeps its own copy of the
// pipeline state and register file, predicts each result and compares.
// ----------------------------------------------------------------------------
module mfps_checker
  import mfps_pkg::*;
#(
  parameter int DATA_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] instruction,
  input  logic [31:0] pc_plus_4,
  input  logic [9:0]  access_index,
  input  logic [31:0] write_data,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic        stall_res,
  input  logic [1:0]  branch_control,
  input  logic [31:0] target_address,
  input  logic        invalid_instruction,
  input  logic [31:0] read_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        stall;
    logic [1:0]  bc;
    logic [31:0] target;
    logic        inval;
    logic [31:0] rdata;
  } outcome_t;

  outcome_t    outcome_q[$];
  logic [31:0] regs[32];
  logic [31:0] dmem[DATA_WORDS];
  idex_t       idex;
  exmem_t      exmem;
  memwb_t      memwb;
  logic [31:0] memwb_load;

  assign pending = outcome_q.size();

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  function automatic logic [31:0] sext(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] wb_value();
    return memwb.m2r ? memwb_load : memwb.alu_res;
  endfunction

  function automatic logic [31:0] bypass(logic [4:0] r, logic [31:0] dflt);
    if (exmem.reg_wr && exmem.wreg == r && r != 0) return exmem.alu_res;
    if (memwb.reg_wr && memwb.wreg == r && r != 0) return wb_value();
    return dflt;
  endfunction

  function automatic logic [31:0] alu_eval(alu_op_t op, logic ng, logic [31:0] a,
                                           logic [31:0] b);
    case (op)
      ALU_AND: return a & b;
      ALU_OR:  return ng ? ~(a | b) : (a | b);
      ALU_ADD: return ng ? a - b : a + b;
      ALU_SLT: return {31'd0, $signed(a) < $signed(b)};
      ALU_XOR: return a ^ b;
      default: return '0;
    endcase
  endfunction

  // Advance the model pipeline by one step and fill in the expected outcome
  task automatic step_pipeline(logic [31:0] ins, logic [31:0] pc4, inout outcome_t o);
    idex_t       n_idex;
    exmem_t      n_exmem;
    memwb_t      n_memwb;
    logic [31:0] n_load, a, b, v, rsv, rtv;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, iw;
    logic        ld, stl, ok, carry;
    idex_ctl_t   c;
    n_idex = '0;
    n_load = '0;
    // write back
    if (memwb.reg_wr && memwb.wreg != 0) regs[memwb.wreg] = wb_value();
    // memory, with store data forwarded from write back
    if (exmem.mem_rd) n_load = dmem[(exmem.alu_res >> 2) % DATA_WORDS];
    else if (exmem.mem_wr) begin
      v = exmem.rt_val;
      if (memwb.reg_wr && memwb.wreg == exmem.rt && exmem.rt != 0) v = wb_value();
      dmem[(exmem.alu_res >> 2) % DATA_WORDS] = v;
    end
    n_memwb.reg_wr = exmem.reg_wr;
    n_memwb.m2r = exmem.m2r;
    n_memwb.wreg = exmem.wreg;
    n_memwb.alu_res = exmem.alu_res;
    // execute
    a = bypass(idex.rs, idex.a_val);
    case (idex.ctl.src)
      SRC_SEXT: b = sext(idex.imm);
      SRC_ZEXT: b = {16'd0, idex.imm};
      SRC_LUI:  b = {idex.imm, 16'd0};
      default:  b = bypass(idex.rt, idex.b_val);
    endcase
    n_exmem.alu_res = alu_eval(idex.ctl.alu_op, idex.ctl.neg, a, b);
    n_exmem.reg_wr = idex.ctl.reg_wr;
    n_exmem.mem_rd = idex.ctl.mem_rd;
    n_exmem.mem_wr = idex.ctl.mem_wr;
    n_exmem.m2r = idex.ctl.m2r;
    n_exmem.wreg = idex.ctl.reg_dst ? idex.rd : idex.rt;
    n_exmem.rt = idex.rt;
    n_exmem.rt_val = idex.b_val;
    // decode
    op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11]; fn = ins[5:0];
    rsv = regs[rs]; rtv = regs[rt];
    ld = idex.ctl.mem_rd && idex.ctl.reg_wr;
    iw = idex.ctl.reg_dst ? idex.rd : idex.rt;
    stl = 0;
    case (op)
      OP_RTYPE: stl = ld && (idex.rt == rs || idex.rt == rt);
      OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_LUI, OP_LW:
        stl = ld && idex.rt == rs;
      OP_SW: begin
        if (ld && idex.rt == rs) stl = 1;
        else if (idex.ctl.reg_wr && iw == rt) stl = 0;
        else stl = exmem.reg_wr && exmem.wreg == rt && rt != 0;
      end
      default: stl = 0;
    endcase
    o.stall = stl;
    if (!stl) begin
      ok = 1; carry = 1; c = '0;
      case (op)
        OP_RTYPE: begin
          case (fn)
            FN_NOP:          c = '{SRC_RT, ALU_ZERO, 0, 0, 0, 0, 1, 1};
            FN_ADD, FN_ADDU: c = '{SRC_RT, ALU_ADD, 0, 0, 0, 0, 1, 1};
            FN_SUB, FN_SUBU: c = '{SRC_RT, ALU_ADD, 1, 0, 0, 0, 1, 1};
            FN_AND:          c = '{SRC_RT, ALU_AND, 0, 0, 0, 0, 1, 1};
            FN_OR:           c = '{SRC_RT, ALU_OR, 0, 0, 0, 0, 1, 1};
            FN_XOR:          c = '{SRC_RT, ALU_XOR, 0, 0, 0, 0, 1, 1};
            FN_NOR:          c = '{SRC_RT, ALU_OR, 1, 0, 0, 0, 1, 1};
            FN_SLT:          c = '{SRC_RT, ALU_SLT, 1, 0, 0, 0, 1, 1};
            default:         ok = 0;
          endcase
        end
        OP_BEQ, OP_BNE: begin
          carry = 0;
          if ((rsv == rtv) == (op == OP_BEQ)) begin
            o.bc = BC_TAKEN;
            o.target = pc4 + (sext(ins[15:0]) << 2);
          end
        end
        OP_J: begin
          carry = 0;
          o.bc = BC_JUMP;
          o.target = {pc4[31:28], ins[25:0], 2'b00};
        end
        OP_ADDI, OP_ADDIU: c = '{SRC_SEXT, ALU_ADD, 0, 0, 0, 0, 0, 1};
        OP_SLTI:  c = '{SRC_SEXT, ALU_SLT, 1, 0, 0, 0, 0, 1};
        OP_ANDI:  c = '{SRC_ZEXT, ALU_AND, 0, 0, 0, 0, 0, 1};
        OP_ORI:   c = '{SRC_ZEXT, ALU_OR, 0, 0, 0, 0, 0, 1};
        OP_LUI:   c = '{SRC_LUI, ALU_ADD, 0, 0, 0, 0, 0, 1};
        OP_LW:    c = '{SRC_SEXT, ALU_ADD, 0, 1, 0, 1, 0, 1};
        OP_SW:    c = '{SRC_SEXT, ALU_ADD, 0, 0, 1, 0, 0, 0};
        default:  ok = 0;
      endcase
      o.inval = !ok;
      if (ok && carry) n_idex = '{c, rs, rt, rd, rsv, rtv, ins[15:0]};
    end
    idex = n_idex; exmem = n_exmem; memwb = n_memwb; memwb_load = n_load;
  endtask

  // Predict on each request transfer, compare on each result transfer
  always @(posedge clk) begin
    outcome_t o, w;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      idex = '0; exmem = '0; memwb = '0; memwb_load = '0;
      fail_count = 0;
      outcome_q.delete();
    end else begin
      if (req_valid && req_ready) begin
        o = '0;
        case (req_type)
          REQ_STEP:     step_pipeline(instruction, pc_plus_4, o);
          REQ_DM_WRITE: dmem[access_index % DATA_WORDS] = write_data;
          REQ_DM_READ:  o.rdata = dmem[access_index % DATA_WORDS];
          REQ_RF_WRITE: if (access_index >= 1 && access_index < 32)
                          regs[access_index[4:0]] = write_data;
          REQ_RF_READ:  o.rdata = access_index < 32 ? regs[access_index[4:0]] : '0;
          default: ;
        endcase
        outcome_q.push_back(o);
      end
      if (res_valid && res_ready) begin
        if (outcome_q.size() == 0) report("unexpected result", 0, 0);
        else begin
          w = outcome_q.pop_front();
          if (stall_res !== w.stall) report("stall_res", stall_res, w.stall);
          if (branch_control !== w.bc) report("branch_control", branch_control, w.bc);
          if (target_address !== w.target) report("target_address", target_address, w.target);
          if (invalid_instruction !== w.inval)
            report("invalid_instruction", invalid_instruction, w.inval);
          if (read_data !== w.rdata) report("read_data", read_data, w.rdata);
        end
      end
    end
  end

endmodule

[test/tb_mips_five_stage_pipeline_step.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mips_five_stage_pipeline_step
// Drives register and memory loads, directed instruction words and random
// short programs into the pipeline step block with random idling; the
// checker predicts every result.
// ----------------------------------------------------------------------------
module tb_mips_five_stage_pipeline_step;
  import mfps_pkg::*;

  logic        clk = 0, rst = 1;
  logic        req_valid = 0, req_ready, res_valid, res_ready = 0;
  logic [2:0]  req_type = REQ_STEP;
  logic [31:0] instruction = '0, pc_plus_4 = '0, write_data = '0;
  logic [9:0]  access_index = '0;
  logic        stall_res, invalid_instruction;
  logic [1:0]  branch_control;
  logic [31:0] target_address, read_data;
  int          fail_count, pending, cycles = 0;
  bit          calm = 0;
  bit          written[1024];

  localparam int LIMIT = 400000;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  mips_five_stage_pipeline_step dut (.*);
  mfps_checker chk (.*);

  // Stall the result side at random, except during the calm stretch
  always @(posedge clk) begin
    if (rst) res_ready <= 0;
    else res_ready <= calm || ($urandom_range(99) >= 10);
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one request and hold it until transfer
  task automatic send(logic [2:0] t, logic [31:0] ins, logic [31:0] pc4,
                      logic [9:0] idx, logic [31:0] wd);
    while (!calm && $urandom_range(99) < 10) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1; req_type <= t; instruction <= ins;
    pc_plus_4 <= pc4; access_index <= idx; write_data <= wd;
    if (t == REQ_DM_WRITE) written[idx] = 1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rtype(logic [4:0] rs, rt, rd, logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Byte offset of a word in the filled region, for a load or store with a zero base
  function automatic logic [15:0] mem_off();
    return {10'd0, 4'($urandom_range(15)), 2'b00};
  endfunction

  // Random instruction: mostly legal, loads only over the filled region
  function automatic logic [31:0] rand_ins();
    logic [4:0] rs, rt, rd;
    logic [31:0] w;
    logic [5:0] fns[10] = '{FN_NOP, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
                            FN_XOR, FN_NOR, FN_SLT};
    logic [5:0] ops[9] = '{OP_BEQ, OP_BNE, OP_J, OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI,
                           OP_ORI, OP_LUI};
    rs = $urandom_range(7); rt = $urandom_range(7); rd = $urandom_range(7);
    case ($urandom_range(9))
      0, 1, 2: return rtype(rs, rt, rd, fns[$urandom_range(9)]);
      3, 4, 5: return {ops[$urandom_range(8)], rs, rt, 16'($urandom)};
      6:       return itype(OP_LW, 5'd0, rt, mem_off());
      7:       return itype(OP_SW, 5'd0, rt, mem_off());
      8: begin
        w = $urandom;
        if (w[31:26] == OP_LW) w = itype(OP_LW, 5'd0, w[20:16], mem_off());
        return w;
      end
      default: return rtype(rs, rt, rd, 6'($urandom));
    endcase
  endfunction

  initial begin
    logic [9:0] ix;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // fill the load region and some registers
    for (int i = 0; i < 16; i++) send(REQ_DM_WRITE, 0, 0, 10'(i), $urandom);
    send(REQ_RF_WRITE, 0, 0, 10'd1, 32'hFFFF_FFFF);
    send(REQ_RF_WRITE, 0, 0, 10'd2, 32'h8000_0000);
    send(REQ_RF_WRITE, 0, 0, 10'd3, 32'h7FFF_FFFF);
    send(REQ_RF_WRITE, 0, 0, 10'd0, 32'h1234_5678);
    send(REQ_RF_WRITE, 0, 0, 10'd40, 32'h1);
    // directed words: a range of operations, hazards and edge cases
    send(REQ_STEP, rtype(1, 2, 4, FN_SLT), 32'hFFFF_FFFC, 0, 0);
    send(REQ_STEP, rtype(4, 3, 5, FN_ADD), 0, 0, 0);
    send(REQ_STEP, rtype(5, 1, 0, FN_SUB), 0, 0, 0);
    send(REQ_STEP, rtype(2, 3, 6, FN_NOR), 0, 0, 0);
    send(REQ_STEP, itype(OP_LW, 0, 7, 16'd8), 0, 0, 0);
    send(REQ_STEP, rtype(7, 1, 8, FN_XOR), 0, 0, 0);
    send(REQ_STEP, itype(OP_SW, 0, 7, 16'd12), 0, 0, 0);
    send(REQ_STEP, itype(OP_ADDI, 1, 9, 16'h8000), 0, 0, 0);
    send(REQ_STEP, itype(OP_SW, 0, 9, 16'd4), 0, 0, 0);
    send(REQ_STEP, itype(OP_SLTI, 2, 10, 16'h7FFF), 0, 0, 0);
    send(REQ_STEP, itype(OP_LUI, 0, 11, 16'hFFFF), 0, 0, 0);
    send(REQ_STEP, itype(OP_ANDI, 1, 12, 16'hFFFF), 0, 0, 0);
    send(REQ_STEP, itype(OP_ORI, 0, 13, 16'h0001), 0, 0, 0);
    send(REQ_STEP, itype(OP_BEQ, 0, 0, 16'h8000), 32'h0000_0004, 0, 0);
    send(REQ_STEP, itype(OP_BNE, 1, 0, 16'h7FFF), 32'hFFFF_FFFC, 0, 0);
    send(REQ_STEP, {OP_J, 26'h3FF_FFFF}, 32'hFFFF_FFFF, 0, 0);
    send(REQ_STEP, 32'hFFFF_FFFF, 0, 0, 0);
    send(REQ_STEP, rtype(0, 0, 0, 6'd1), 0, 0, 0);
    send(REQ_RF_READ, 0, 0, 10'd1023, 0);
    send(REQ_DM_READ, 0, 0, 10'd3, 0);
    send(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
    // random part: short programs with occasional direct accesses
    for (int n = 0; n < 1700; n++) begin
      calm = (n >= 600 && n < 800);
      case ($urandom_range(19))
        0: send(REQ_DM_WRITE, $urandom, $urandom, 10'($urandom), $urandom);
        1: begin
          ix = 10'($urandom);
          if (!written[ix]) ix = 10'($urandom_range(15));
          send(REQ_DM_READ, $urandom, $urandom, ix, $urandom);
        end
        2: send(REQ_RF_WRITE, $urandom, $urandom, 10'($urandom_range(40)), $urandom);
        3: send(REQ_RF_READ, $urandom, $urandom, 10'($urandom_range(40)), $urandom);
        4: send(3'($urandom_range(7)), rand_ins(), $urandom, 10'($urandom_range(15)),
                $urandom);
        default: send(REQ_STEP, rand_ins(), $urandom, 10'($urandom), $urandom);
      endcase
    end
    req_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
hdl/mfps_pkg.sv
hdl/mfps_ram.sv
hdl/mips_five_stage_pipeline_step.sv
test/mfps_checker.sv
test/tb_mips_five_stage_pipeline_step.sv
